// File: rtl/core/newton_divided_difference_interp_assert.svh
// Assertion macros for the interpolator checker.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH

// Implication checked every clock, disabled in reset.
`define NDD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define NDD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// File: rtl/core/ndd_pkg.sv
package ndd_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic       FUNC_LOAD    = 1'b0;
    localparam logic       FUNC_EVAL    = 1'b1;
    localparam logic       KIND_LOAD    = 1'b0;
    localparam logic       KIND_EVAL    = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_REPEAT    = 2'd1;
    localparam logic [1:0] ST_NODATA    = 2'd2;
    localparam logic [1:0] ST_SAT       = 2'd3;

    typedef struct packed {
        logic               func;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
        logic signed [31:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] interp_value;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_STORE  = 4'd1,
        OP_CMP    = 4'd2,
        OP_DIFF   = 4'd3,
        OP_DIVST  = 4'd4,
        OP_DIVWR  = 4'd5,
        OP_EVINIT = 4'd6,
        OP_EVADD  = 4'd7,
        OP_EVMUL  = 4'd8,
        OP_EVWR   = 4'd9,
        OP_RDPAIR = 4'd10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [8:0] ia;
        logic [8:0] ib;
        logic [8:0] ic;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic eq;
        logic ovf;
    } stat_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v,
                                                 inout logic ovf);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > 33'sd2147483647) begin
            r = 32'sh7fffffff;
            ovf = 1'b1;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
            ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/ndd_datapath.sv
module ndd_datapath #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ndd_pkg::cmd_t       cmd,
    input  ndd_pkg::in_item_t   item,
    output ndd_pkg::stat_t      stat,
    output logic signed [31:0]  acc
);
    import ndd_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic signed [31:0] xmem [MAX_POINTS];
    logic signed [31:0] cmem [MAX_POINTS];
    logic signed [31:0] xa_reg, xb_reg, ca_reg, cb_reg;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] qx_reg, qx_next;
    logic               ovf_reg, ovf_next;
    logic [NW-1:0]      rem_reg, quo_reg, den_reg;
    logic [NW-1:0]      rem_next, quo_next, den_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               dbusy_reg, dbusy_next;
    logic signed [32:0] dy, dx, qsub;
    logic [32:0]        mdy, mdx;
    logic [NW:0]        trial;
    logic [63:0]        prod_reg, prod_next;
    logic               mneg_reg, mneg_next, mbusy_reg, mbusy_next;
    logic [31:0]        ma, mb;
    logic [63:0]        psh;
    logic [NW-1:0]      qmag;
    logic signed [31:0] qval, dval;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_STORE)
        begin
            xmem[cmd.ia[AW-1:0]] <= item.point_x;
            cmem[cmd.ia[AW-1:0]] <= item.point_y;
        end
        if (cmd.op == OP_DIVWR)
            cmem[cmd.ic[AW-1:0]] <= qval;
        xa_reg <= xmem[cmd.ia[AW-1:0]];
        xb_reg <= xmem[cmd.ib[AW-1:0]];
        if (cmd.op != OP_DIFF)
        begin
            ca_reg <= cmem[cmd.ia[AW-1:0]];
            cb_reg <= cmem[cmd.ib[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            mbusy_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            dbusy_reg <= dbusy_next;
            mbusy_reg <= mbusy_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        qx_reg   <= qx_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        mneg_reg <= mneg_next;
    end

    always_comb
    begin
        dy    = 33'(ca_reg) - 33'(cb_reg);
        dx    = 33'(xa_reg) - 33'(xb_reg);
        mdy   = dy[32] ? 33'(-dy) : 33'(dy);
        mdx   = dx[32] ? 33'(-dx) : 33'(dx);
        trial = {rem_reg, quo_reg[NW-1]} - {1'b0, den_reg};
        qmag  = quo_reg;
        qval  = 32'sh0;
        dval  = 32'sh0;
        qsub  = 33'(qx_reg) - 33'(xa_reg);
        ma    = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
        psh   = prod_reg >> FRAC_BITS;
        acc_next   = acc_reg;
        qx_next    = qx_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        dbusy_next = dbusy_reg;
        prod_next  = prod_reg;
        mneg_next  = mneg_reg;
        mbusy_next = 1'b0;
        mb         = 32'd0;
        if (neg_reg)
        begin
            if (qmag > NW'(33'h080000000))
            begin
                qval = 32'sh80000000;
            end
            else
                qval = 32'(-qmag);
        end
        else if (qmag > NW'(33'h07fffffff))
            qval = 32'sh7fffffff;
        else
            qval = qmag[31:0];
        if (dbusy_reg)
        begin
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[NW-2:0], quo_reg[NW-1]};
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                dbusy_next = 1'b0;
        end
        if (mbusy_reg)
        begin
            if (mneg_reg)
            begin
                if (psh > 64'h80000000)
                begin
                    acc_next = 32'sh80000000;
                    ovf_next = 1'b1;
                end
                else
                    acc_next = 32'(-psh);
            end
            else if (psh > 64'h7fffffff)
            begin
                acc_next = 32'sh7fffffff;
                ovf_next = 1'b1;
            end
            else
                acc_next = psh[31:0];
        end
        case (cmd.op)
            OP_CMP:
            begin
                ovf_next = 1'b0;
            end
            OP_DIVST:
            begin
                rem_next   = '0;
                quo_next   = NW'(mdy) << FRAC_BITS;
                den_next   = NW'(mdx);
                neg_next   = dy[32] ^ dx[32];
                cnt_next   = CW'(NW);
                dbusy_next = 1'b1;
            end
            OP_DIVWR:
            begin
                if (neg_reg ? (qmag > NW'(33'h080000000)) : (qmag > NW'(33'h07fffffff)))
                    ovf_next = 1'b1;
            end
            OP_EVINIT:
            begin
                acc_next = 32'sh0;
                ovf_next = 1'b0;
                qx_next  = item.query_x;
            end
            OP_EVADD:
            begin
                acc_next = sat33(33'(acc_reg) + 33'(ca_reg), ovf_next);
            end
            OP_EVMUL:
            begin
                dval       = sat33(qsub, ovf_next);
                mb         = dval[31] ? 32'(-dval) : 32'(dval);
                prod_next  = 64'(ma) * 64'(mb);
                mneg_next  = acc_reg[31] ^ dval[31];
                mbusy_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.div_done = !dbusy_reg;
    assign stat.mul_done = !mbusy_reg;
    assign stat.eq       = (xa_reg == xb_reg);
    assign stat.ovf      = ovf_reg;
    assign acc           = acc_reg;
    logic unused;
    assign unused = ^{dval, cmd.ic};

endmodule

// File: rtl/core/ndd_ctrl.sv
module ndd_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ndd_pkg::in_item_t item,
    output ndd_pkg::cmd_t     cmd,
    input  ndd_pkg::stat_t    stat,
    input  logic signed [31:0] acc,
    output logic              out_valid,
    input  logic              out_ready,
    output ndd_pkg::out_item_t res
);
    import ndd_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CMPRD = 11'b00000000010,
        S_CMPCK = 11'b00000000100,
        S_DVRD  = 11'b00000001000,
        S_DVST  = 11'b00000010000,
        S_DVWT  = 11'b00000100000,
        S_EVRD  = 11'b00001000000,
        S_EVADD = 11'b00010000000,
        S_EVMUL = 11'b00100000000,
        S_EVWT  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam int PW = $clog2(MAX_POINTS + 1);

    state_t          state_reg, state_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic            valid_reg, valid_next;
    logic [8:0]      i_reg, i_next, j_reg, j_next, k_reg, k_next;
    out_item_t       res_reg, res_next;
    logic            acc_ok;
    logic            sat_fix;
    logic [8:0]      n9;

    assign acc_ok   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign sat_fix  = (state_reg == S_OUT) && res_reg.result_kind == KIND_LOAD
                      && res_reg.status == ST_OK && valid_reg && stat.ovf;
    assign out_valid = (state_reg == S_OUT) && !sat_fix;
    assign res      = res_reg;
    assign n9       = 9'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        cmd        = '{op: OP_NONE, ia: i_reg, ib: j_reg, ic: j_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (acc_ok && item.func == FUNC_LOAD)
                begin
                    automatic logic [PW-1:0] c = valid_reg ? '0 : cnt_reg;
                    valid_next = 1'b0;
                    if (c < PW'(MAX_POINTS))
                    begin
                        cmd.op = OP_STORE;
                        cmd.ia = 9'(c);
                        c = c + 1'b1;
                    end
                    cnt_next = c;
                    if (item.last_point)
                    begin
                        res_next = '{result_kind: KIND_LOAD, interp_value: 32'sh0,
                                     status: ST_OK};
                        i_next = 9'd0;
                        j_next = 9'd1;
                        state_next = S_CMPRD;
                    end
                end
                else if (acc_ok)
                begin
                    res_next = '{result_kind: KIND_EVAL, interp_value: 32'sh0,
                                 status: ST_NODATA};
                    if (valid_reg)
                    begin
                        i_next = n9 - 9'd1;
                        state_next = S_EVRD;
                        cmd.op = OP_EVINIT;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_CMPRD:
            begin
                if (j_reg >= n9)
                begin
                    if (n9 <= 9'd1)
                    begin
                        cmd.op = OP_CMP;
                        valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next = 9'd0;
                        k_next = 9'd1;
                        j_next = n9 - 9'd1;
                        state_next = S_DVRD;
                    end
                end
                else
                begin
                    cmd.op = (i_reg == 9'd0 && j_reg == 9'd1) ? OP_CMP : OP_RDPAIR;
                    state_next = S_CMPCK;
                end
            end
            S_CMPCK:
            begin
                if (stat.eq)
                begin
                    res_next.status = ST_REPEAT;
                    cnt_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    if (j_reg + 9'd1 >= n9)
                    begin
                        i_next = i_reg + 9'd1;
                        j_next = i_reg + 9'd2;
                    end
                    else
                        j_next = j_reg + 9'd1;
                    state_next = S_CMPRD;
                end
            end
            S_DVRD:
            begin
                cmd.ia = j_reg;
                cmd.ib = j_reg - 9'd1;
                cmd.op = OP_RDPAIR;
                state_next = S_DVST;
            end
            S_DVST:
            begin
                cmd.ia = j_reg;
                cmd.ib = j_reg - k_reg;
                cmd.op = OP_DIFF;
                state_next = S_DVWT;
            end
            S_DVWT:
            begin
                if (i_reg == 9'd0)
                begin
                    cmd.op = OP_DIVST;
                    i_next = 9'd1;
                end
                else if (stat.div_done)
                begin
                    cmd.op = OP_DIVWR;
                    cmd.ic = j_reg;
                    i_next = 9'd0;
                    if (j_reg > k_reg)
                    begin
                        j_next = j_reg - 9'd1;
                        state_next = S_DVRD;
                    end
                    else if (k_reg + 9'd1 < n9)
                    begin
                        k_next = k_reg + 9'd1;
                        j_next = n9 - 9'd1;
                        state_next = S_DVRD;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_EVRD:
            begin
                cmd.ia = i_reg;
                cmd.op = OP_RDPAIR;
                state_next = S_EVADD;
            end
            S_EVADD:
            begin
                cmd.op = OP_EVADD;
                if (i_reg == 9'd0)
                begin
                    j_next = 9'd1;
                    state_next = S_EVWT;
                end
                else
                begin
                    i_next = i_reg - 9'd1;
                    state_next = S_EVMUL;
                end
            end
            S_EVMUL:
            begin
                cmd.ia = i_reg;
                cmd.op = OP_RDPAIR;
                j_next = 9'd0;
                state_next = S_EVWT;
            end
            S_EVWT:
            begin
                if (i_reg == 9'd0 && j_reg == 9'd1)
                begin
                    res_next.interp_value = acc;
                    res_next.status = stat.ovf ? ST_SAT : ST_OK;
                    state_next = S_OUT;
                end
                else if (j_reg == 9'd0)
                begin
                    cmd.op = OP_EVMUL;
                    j_next = 9'd2;
                end
                else
                begin
                    cmd.ia = i_reg;
                    cmd.op = OP_RDPAIR;
                    state_next = S_EVADD;
                    j_next = (i_reg == 9'd0) ? 9'd1 : 9'd3;
                end
            end
            S_OUT:
            begin
                if (sat_fix)
                    res_next.status = ST_SAT;
                else if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/newton_divided_difference_interp.sv
// Newton divided-difference interpolator, Q(32-FRAC_BITS).FRAC_BITS fixed point.
// Intermediate load: stored when accepted, while room remains. Closing load: up to
// n*(n-1)/2 pairwise compares plus n*(n-1)/2 divisions on the radix-2 divider.
// Evaluate: nodes in turn through the single multiplier; one request at a time.
// Asynchronous active-low reset clears the set; stores hold no reset value.
module newton_divided_difference_interp #(
    parameter int MAX_POINTS = ndd_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = ndd_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ndd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ndd_pkg::out_item_t out_data
);
    import ndd_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic signed [31:0] acc;

    ndd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .item(in_data), .cmd(cmd), .stat(stat), .acc(acc),
        .out_valid(out_valid), .out_ready(out_ready), .res(out_data)
    );

    ndd_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(in_data), .stat(stat), .acc(acc)
    );

endmodule

// File: rtl/core/ndd_checker.sv
`include "newton_divided_difference_interp_assert.svh"
module ndd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ndd_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input ndd_pkg::out_item_t out_data
);
    import ndd_pkg::*;

    `NDD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `NDD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `NDD_ASSERT_IMP(a_load_zero, clk, rst_n, out_valid && out_data.result_kind == KIND_LOAD, out_data.interp_value == 32'sh0)
    `NDD_ASSERT_IMP(a_nodata_zero, clk, rst_n, out_valid && out_data.status == ST_NODATA, out_data.interp_value == 32'sh0)

    logic unused;
    assign unused = ^{in_valid, in_data};
endmodule

bind newton_divided_difference_interp ndd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
